// ===== rtl/bmma_pkg.sv =====
// Shared types, codes and constants for the blocked matrix multiply-accumulate block.
// No dependencies; every other file in rtl/ imports this package.
package bmma_pkg;

    localparam int unsigned MAX_ORDER_DEF = 64;
    localparam int unsigned ACC_BITS_DEF  = 40;

    localparam int unsigned REQ_W   = 3;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned VALUE_W = 40;
    localparam int unsigned CFG_W   = 7;
    localparam int unsigned AB_W    = 16;

    localparam logic [CFG_W-1:0] MATRIX_SIZE_RST = 7'd64;
    localparam logic [CFG_W-1:0] GRID_COUNT_RST  = 7'd8;

    // Register indexes
    localparam logic CFG_MATRIX_SIZE = 1'b0;
    localparam logic CFG_GRID_COUNT  = 1'b1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD_A  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_B  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LOAD_C  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_COMPUTE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ_C  = 3'd4;

    typedef enum logic [1:0] {
        CW_LOAD,
        CW_CLEAR,
        CW_MAC
    } c_wsel_t;

    typedef struct packed {
        logic    a_we;
        logic    b_we;
        logic    c_we;
        c_wsel_t c_wsel;
        logic    c_re;
        logic    c_rsel_req;
        logic    rd_capture;
        logic    div_start;
        logic    mac_issue;
        logic    acc_clear;
        logic    out_load;
        logic    out_done;
    } bmma_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mac_busy;
    } bmma_stat_t;

    // Saturate a Q32.8 input word to the Q8.8 range
    function automatic logic signed [AB_W-1:0] sat_ab(input logic signed [VALUE_W-1:0] v);
        logic signed [AB_W-1:0] r;
        if (v > $signed({{(VALUE_W-AB_W){1'b0}}, 1'b0, {(AB_W-1){1'b1}}})) begin
            r = {1'b0, {(AB_W-1){1'b1}}};
        end else if (v < $signed({{(VALUE_W-AB_W){1'b1}}, 1'b1, {(AB_W-1){1'b0}}})) begin
            r = {1'b1, {(AB_W-1){1'b0}}};
        end else begin
            r = v[AB_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/bmma_datapath.sv =====
// Datapath: A, B and C stores, input saturation, the block-size divider,
// the multiply-accumulate pipeline, saturating C update and the result register.
// Depends on bmma_pkg.
module bmma_datapath #(
    parameter int unsigned MAX_ORDER = 64,
    parameter int unsigned ACC_BITS  = 40,
    parameter int unsigned LW        = $clog2(MAX_ORDER),
    parameter int unsigned NW        = $clog2(MAX_ORDER + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [bmma_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic [bmma_pkg::IDX_W-1:0]          s_row,
    input  logic [bmma_pkg::IDX_W-1:0]          s_col,
    input  logic signed [bmma_pkg::VALUE_W-1:0] s_value,
    input  bmma_pkg::bmma_cmd_t                 cmd,
    output bmma_pkg::bmma_stat_t                stat,
    input  logic [2*LW-1:0]                     ctrl_a_addr,
    input  logic [2*LW-1:0]                     ctrl_b_addr,
    input  logic [2*LW-1:0]                     ctrl_c_addr,
    output logic [NW-1:0]                       grid_n,
    output logic [NW-1:0]                       side_n,
    output logic signed [bmma_pkg::VALUE_W-1:0] m_result_value,
    output logic                                m_compute_done
);
    import bmma_pkg::*;

    localparam int unsigned AW     = 2 * LW;
    localparam int unsigned DEPTH  = 1 << AW;
    localparam int unsigned PROD_W = 2 * AB_W;
    localparam int unsigned SUM_W  = PROD_W + 1 + $clog2(MAX_ORDER);
    localparam int unsigned TW     = ((ACC_BITS > SUM_W) ? ACC_BITS : SUM_W) + 1;
    localparam logic signed [63:0] ACC_MAX64 = (64'sd1 <<< (ACC_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] ACC_MIN64 = -ACC_MAX64 - 64'sd1;
    localparam logic signed [TW-1:0] ACC_MAX_T = TW'(ACC_MAX64);
    localparam logic signed [TW-1:0] ACC_MIN_T = TW'(ACC_MIN64);

    logic signed [AB_W-1:0]     a_mem [DEPTH];
    logic signed [AB_W-1:0]     b_mem [DEPTH];
    logic signed [ACC_BITS-1:0] c_mem [DEPTH];

    logic [CFG_W-1:0]           size_cfg_reg;
    logic [CFG_W-1:0]           grid_cfg_reg;
    logic [NW-1:0]              order_n;
    logic [NW-1:0]              rem_reg;
    logic [NW-1:0]              quot_reg;
    logic                       div_busy_reg;

    logic                       in_store;
    logic [AW-1:0]              req_addr;
    logic signed [AB_W-1:0]     a_q_reg;
    logic signed [AB_W-1:0]     b_q_reg;
    logic signed [ACC_BITS-1:0] c_q_reg;
    logic                       rd_inside_reg;
    logic                       v1_reg;
    logic                       v2_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    sum_reg;

    logic signed [63:0]         val64;
    logic signed [ACC_BITS-1:0] c_load;
    logic signed [TW-1:0]       c_sum;
    logic signed [ACC_BITS-1:0] c_upd;
    logic signed [ACC_BITS-1:0] c_wdata;
    logic [AW-1:0]              c_waddr;
    logic [AW-1:0]              c_raddr;
    logic                       c_we_eff;

    assign in_store = (int'(s_row) < MAX_ORDER) && (int'(s_col) < MAX_ORDER);
    assign req_addr = {LW'(s_row), LW'(s_col)};

    // Clamp the configured sizes into 1 .. MAX_ORDER
    always_comb begin
        if (size_cfg_reg == '0) begin
            order_n = NW'(1);
        end else if (int'(size_cfg_reg) > MAX_ORDER) begin
            order_n = NW'(MAX_ORDER);
        end else begin
            order_n = NW'(size_cfg_reg);
        end
        if (grid_cfg_reg == '0) begin
            grid_n = NW'(1);
        end else if (int'(grid_cfg_reg) > MAX_ORDER) begin
            grid_n = NW'(MAX_ORDER);
        end else begin
            grid_n = NW'(grid_cfg_reg);
        end
    end

    assign side_n        = quot_reg;
    assign stat.div_done = !div_busy_reg;
    assign stat.mac_busy = v1_reg || v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_cfg_reg <= MATRIX_SIZE_RST;
            grid_cfg_reg <= GRID_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MATRIX_SIZE: size_cfg_reg <= cfg_wr_data;
                CFG_GRID_COUNT:  grid_cfg_reg <= cfg_wr_data;
                default:         size_cfg_reg <= size_cfg_reg;
            endcase
        end
    end

    // Block side by repeated subtraction, one step a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            rem_reg      <= '0;
            quot_reg     <= '0;
        end else if (cmd.div_start) begin
            div_busy_reg <= 1'b1;
            rem_reg      <= order_n;
            quot_reg     <= '0;
        end else if (div_busy_reg) begin
            if (rem_reg >= grid_n) begin
                rem_reg  <= rem_reg - grid_n;
                quot_reg <= quot_reg + NW'(1);
            end else begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    // A and B stores
    always_ff @(posedge aclk) begin
        if (cmd.a_we && in_store) begin
            a_mem[req_addr] <= sat_ab(s_value);
        end
        if (cmd.b_we && in_store) begin
            b_mem[req_addr] <= sat_ab(s_value);
        end
        a_q_reg <= a_mem[ctrl_a_addr];
        b_q_reg <= b_mem[ctrl_b_addr];
    end

    // Multiply-accumulate pipeline: read, multiply, sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
        end
        prod_reg <= a_q_reg * b_q_reg;
        if (cmd.acc_clear) begin
            sum_reg <= '0;
        end else if (v2_reg) begin
            sum_reg <= sum_reg + SUM_W'(prod_reg);
        end
    end

    // C write data
    always_comb begin
        val64 = 64'(s_value);
        if (val64 > ACC_MAX64) begin
            c_load = ACC_BITS'(ACC_MAX64);
        end else if (val64 < ACC_MIN64) begin
            c_load = ACC_BITS'(ACC_MIN64);
        end else begin
            c_load = ACC_BITS'(val64);
        end
        c_sum = TW'(c_q_reg) + TW'(sum_reg);
        if (c_sum > ACC_MAX_T) begin
            c_upd = ACC_BITS'(ACC_MAX_T);
        end else if (c_sum < ACC_MIN_T) begin
            c_upd = ACC_BITS'(ACC_MIN_T);
        end else begin
            c_upd = ACC_BITS'(c_sum);
        end
        unique case (cmd.c_wsel)
            CW_LOAD:  c_wdata = c_load;
            CW_CLEAR: c_wdata = '0;
            CW_MAC:   c_wdata = c_upd;
            default:  c_wdata = '0;
        endcase
        c_waddr  = (cmd.c_wsel == CW_LOAD) ? req_addr : ctrl_c_addr;
        c_raddr  = cmd.c_rsel_req ? req_addr : ctrl_c_addr;
        c_we_eff = cmd.c_we && ((cmd.c_wsel != CW_LOAD) || in_store);
    end

    always_ff @(posedge aclk) begin
        if (c_we_eff) begin
            c_mem[c_waddr] <= c_wdata;
        end
        if (cmd.c_re) begin
            c_q_reg <= c_mem[c_raddr];
        end
        if (cmd.rd_capture) begin
            rd_inside_reg <= in_store;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_compute_done <= cmd.out_done;
            if (cmd.out_done || !rd_inside_reg) begin
                m_result_value <= '0;
            end else begin
                m_result_value <= VALUE_W'(c_q_reg);
            end
        end
    end

endmodule

// ===== rtl/bmma_controller.sv =====
// Controller: request decode, clearing pass, Cannon block sequencing and result handshake.
// Depends on bmma_pkg; drives the datapath through bmma_cmd_t.
module bmma_controller #(
    parameter int unsigned MAX_ORDER = 64,
    parameter int unsigned LW        = $clog2(MAX_ORDER),
    parameter int unsigned NW        = $clog2(MAX_ORDER + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [bmma_pkg::REQ_W-1:0] s_req_type,
    output logic                       m_valid,
    input  logic                       m_ready,
    output bmma_pkg::bmma_cmd_t        cmd,
    input  bmma_pkg::bmma_stat_t       stat,
    input  logic [NW-1:0]              grid_n,
    input  logic [NW-1:0]              side_n,
    output logic [2*LW-1:0]            ctrl_a_addr,
    output logic [2*LW-1:0]            ctrl_b_addr,
    output logic [2*LW-1:0]            ctrl_c_addr
);
    import bmma_pkg::*;

    localparam int unsigned AW = 2 * LW;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_ELEM,
        ST_MAC,
        ST_DRAIN,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic          m_valid_reg, m_valid_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [NW-1:0] bi_reg, bi_next, bj_reg, bj_next, step_reg, step_next;
    logic [NW-1:0] ib_reg, ib_next, jb_reg, jb_next;
    logic [NW-1:0] kb_reg, kb_next, kbase_reg, kbase_next;
    logic [NW-1:0] ks_reg, ks_next, ksbase_reg, ksbase_next;
    logic [NW-1:0] io_reg, io_next, jo_reg, jo_next, ko_reg, ko_next;

    logic [NW-1:0] mi, mj, mk, last_off, last_blk;
    logic          out_free, accept;
    logic          kb_wrap, ks_wrap;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;

    assign mi       = ib_reg + io_reg;
    assign mj       = jb_reg + jo_reg;
    assign mk       = kbase_reg + ko_reg;
    assign last_off = side_n - NW'(1);
    assign last_blk = grid_n - NW'(1);
    assign kb_wrap  = (kb_reg == last_blk);
    assign ks_wrap  = (ks_reg == last_blk);

    assign ctrl_a_addr = {mi[LW-1:0], mk[LW-1:0]};
    assign ctrl_b_addr = {mk[LW-1:0], mj[LW-1:0]};
    assign ctrl_c_addr = (state_reg == ST_CLEAR) ? clr_reg : {mi[LW-1:0], mj[LW-1:0]};

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        clr_next     = clr_reg;
        bi_next      = bi_reg;
        bj_next      = bj_reg;
        step_next    = step_reg;
        ib_next      = ib_reg;
        jb_next      = jb_reg;
        kb_next      = kb_reg;
        kbase_next   = kbase_reg;
        ks_next      = ks_reg;
        ksbase_next  = ksbase_reg;
        io_next      = io_reg;
        jo_next      = jo_reg;
        ko_next      = ko_reg;
        cmd          = '0;
        cmd.c_wsel   = CW_MAC;

        unique case (state_reg)
            ST_CLEAR: begin
                cmd.c_we   = 1'b1;
                cmd.c_wsel = CW_CLEAR;
                clr_next   = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_req_type)
                        REQ_LOAD_A: cmd.a_we = 1'b1;
                        REQ_LOAD_B: cmd.b_we = 1'b1;
                        REQ_LOAD_C: begin
                            cmd.c_we   = 1'b1;
                            cmd.c_wsel = CW_LOAD;
                        end
                        REQ_READ_C: begin
                            cmd.c_re       = 1'b1;
                            cmd.c_rsel_req = 1'b1;
                            cmd.rd_capture = 1'b1;
                            state_next     = ST_READ;
                        end
                        REQ_COMPUTE: begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    bi_next     = '0;
                    bj_next     = '0;
                    step_next   = '0;
                    ib_next     = '0;
                    jb_next     = '0;
                    kb_next     = '0;
                    kbase_next  = '0;
                    ks_next     = '0;
                    ksbase_next = '0;
                    io_next     = '0;
                    jo_next     = '0;
                    // grid wider than the order: nothing to do
                    state_next  = (side_n == '0) ? ST_DONE : ST_ELEM;
                end
            end
            ST_ELEM: begin
                cmd.c_re      = 1'b1;
                cmd.acc_clear = 1'b1;
                ko_next       = '0;
                state_next    = ST_MAC;
            end
            ST_MAC: begin
                cmd.mac_issue = 1'b1;
                ko_next       = ko_reg + NW'(1);
                if (ko_reg == last_off) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.mac_busy) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.c_we   = 1'b1;
                cmd.c_wsel = CW_MAC;
                state_next = ST_ELEM;
                jo_next    = jo_reg + NW'(1);
                if (jo_reg == last_off) begin
                    jo_next = '0;
                    io_next = io_reg + NW'(1);
                    if (io_reg == last_off) begin
                        io_next   = '0;
                        step_next = step_reg + NW'(1);
                        // rotate the inner block index
                        kb_next    = kb_wrap ? '0 : kb_reg + NW'(1);
                        kbase_next = kb_wrap ? '0 : kbase_reg + side_n;
                        if (step_reg == last_blk) begin
                            step_next   = '0;
                            bj_next     = bj_reg + NW'(1);
                            jb_next     = jb_reg + side_n;
                            ks_next     = ks_wrap ? '0 : ks_reg + NW'(1);
                            ksbase_next = ks_wrap ? '0 : ksbase_reg + side_n;
                            kb_next     = ks_wrap ? '0 : ks_reg + NW'(1);
                            kbase_next  = ks_wrap ? '0 : ksbase_reg + side_n;
                            if (bj_reg == last_blk) begin
                                bj_next     = '0;
                                jb_next     = '0;
                                bi_next     = bi_reg + NW'(1);
                                ib_next     = ib_reg + side_n;
                                ks_next     = bi_reg + NW'(1);
                                ksbase_next = ib_reg + side_n;
                                kb_next     = bi_reg + NW'(1);
                                kbase_next  = ib_reg + side_n;
                                if (bi_reg == last_blk) begin
                                    state_next = ST_DONE;
                                end
                            end
                        end
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_done = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
            clr_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            clr_reg     <= clr_next;
        end
        bi_reg     <= bi_next;
        bj_reg     <= bj_next;
        step_reg   <= step_next;
        ib_reg     <= ib_next;
        jb_reg     <= jb_next;
        kb_reg     <= kb_next;
        kbase_reg  <= kbase_next;
        ks_reg     <= ks_next;
        ksbase_reg <= ksbase_next;
        io_reg     <= io_next;
        jo_reg     <= jo_next;
        ko_reg     <= ko_next;
    end

endmodule

// ===== rtl/blocked_matrix_multiply_accumulate.sv =====
// Blocked matrix multiply-accumulate, C += A*B in Cannon block order.
// Input channel s_*: one request per transaction (load A/B/C element, compute, read C).
// Result channel m_*: one transaction per read (C element) and per compute (done flag).
// Configuration: cfg_wr_en/cfg_index/cfg_wr_data write matrix_size and grid_count.
// Request handling:
//   loads are accepted back to back;
//   a read latches the C element, then loads it into the output register once that is free;
//   a compute first finds the block side s = floor(n/g) by repeated subtraction,
//   then updates C block by block with the single multiply-accumulate lane and
//   one read-modify-write of C per element and block step.
// Reset: configuration returns to n=64, g=8; a clearing pass then zeroes all
//   2**(2*clog2(MAX_ORDER)) C store entries (4096 by default), one entry a cycle,
//   with s_ready low. A and B are not cleared.
// Stall: a result waits in the output register while m_ready is low; loads are still
//   taken meanwhile, a further read or compute holds in its final state until the
//   output register is free.
// Depends on bmma_pkg, bmma_controller and bmma_datapath.
module blocked_matrix_multiply_accumulate #(
    parameter int unsigned MAX_ORDER = bmma_pkg::MAX_ORDER_DEF,
    parameter int unsigned ACC_BITS  = bmma_pkg::ACC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [bmma_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bmma_pkg::REQ_W-1:0]          s_req_type,
    input  logic [bmma_pkg::IDX_W-1:0]          s_row,
    input  logic [bmma_pkg::IDX_W-1:0]          s_col,
    input  logic signed [bmma_pkg::VALUE_W-1:0] s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bmma_pkg::VALUE_W-1:0] m_result_value,
    output logic                                m_compute_done
);
    import bmma_pkg::*;

    localparam int unsigned LW = $clog2(MAX_ORDER);
    localparam int unsigned NW = $clog2(MAX_ORDER + 1);

    bmma_cmd_t       cmd;
    bmma_stat_t      stat;
    logic [NW-1:0]   grid_n;
    logic [NW-1:0]   side_n;
    logic [2*LW-1:0] ctrl_a_addr;
    logic [2*LW-1:0] ctrl_b_addr;
    logic [2*LW-1:0] ctrl_c_addr;

    bmma_controller #(
        .MAX_ORDER (MAX_ORDER),
        .LW        (LW),
        .NW        (NW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .stat        (stat),
        .grid_n      (grid_n),
        .side_n      (side_n),
        .ctrl_a_addr (ctrl_a_addr),
        .ctrl_b_addr (ctrl_b_addr),
        .ctrl_c_addr (ctrl_c_addr)
    );

    bmma_datapath #(
        .MAX_ORDER (MAX_ORDER),
        .ACC_BITS  (ACC_BITS),
        .LW        (LW),
        .NW        (NW)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_row          (s_row),
        .s_col          (s_col),
        .s_value        (s_value),
        .cmd            (cmd),
        .stat           (stat),
        .ctrl_a_addr    (ctrl_a_addr),
        .ctrl_b_addr    (ctrl_b_addr),
        .ctrl_c_addr    (ctrl_c_addr),
        .grid_n         (grid_n),
        .side_n         (side_n),
        .m_result_value (m_result_value),
        .m_compute_done (m_compute_done)
    );

endmodule

// ===== rtl/bmma_checker.sv =====
// Port-level checks for the blocked matrix multiply-accumulate block, bound to its top level.
// Depends on bmma_pkg and blocked_matrix_multiply_accumulate.
module bmma_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [bmma_pkg::REQ_W-1:0]          s_req_type,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [bmma_pkg::VALUE_W-1:0] m_result_value,
    input logic                                m_compute_done
);
    import bmma_pkg::*;

    // Clearing pass follows reset: nothing taken, nothing shown
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block ready or result valid right after reset");

    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_compute_done |-> m_result_value == '0)
        else $error("compute done transaction carries a non-zero value");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value)
                                && $stable(m_compute_done))
        else $error("stalled result changed or dropped");

    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == REQ_COMPUTE || s_req_type == REQ_READ_C)
        |=> !s_ready)
        else $error("new transaction taken while a read or compute is in progress");

endmodule

bind blocked_matrix_multiply_accumulate bmma_checker u_bmma_checker (.*);

// ===== sim/blocked_matrix_multiply_accumulate_tb.sv =====
// Self-checking testbench for blocked_matrix_multiply_accumulate: loads, reads and
// Cannon-order computes checked against an in-bench predictor over several sizes.
// Depends on bmma_pkg and the RTL top level only.
`timescale 1ns / 100ps

module blocked_matrix_multiply_accumulate_tb;
    import bmma_pkg::*;

    localparam int unsigned ORDER = 64;
    localparam logic [REQ_W-1:0] REQ_NONE_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_NONE_LAST  = 3'd7;
    localparam longint ACC_MAX = (64'sd1 <<< 39) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam int COMPUTE_BUDGET = 20000;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      done;
    } c_result_t;

    typedef struct {
        logic [REQ_W-1:0]          req;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
        bit                        typed;
        logic signed [VALUE_W-1:0] exp_value;
        logic                      exp_done;
    } stim_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic                      cfg_index = CFG_MATRIX_SIZE;
    logic [CFG_W-1:0]          cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [REQ_W-1:0]          s_req_type = REQ_LOAD_A;
    logic [IDX_W-1:0]          s_row = '0;
    logic [IDX_W-1:0]          s_col = '0;
    logic signed [VALUE_W-1:0] s_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [VALUE_W-1:0] m_result_value;
    logic                      m_compute_done;

    // predictor state
    logic signed [AB_W-1:0]    a_mirror [ORDER*ORDER];
    logic signed [AB_W-1:0]    b_mirror [ORDER*ORDER];
    logic signed [VALUE_W-1:0] c_mirror [ORDER*ORDER];
    bit                        a_written [ORDER*ORDER];
    bit                        b_written [ORDER*ORDER];
    logic [CFG_W-1:0]          size_reg = MATRIX_SIZE_RST;
    logic [CFG_W-1:0]          grid_reg = GRID_COUNT_RST;

    c_result_t pending_results[$];
    int        mismatches = 0;
    int        results_seen = 0;
    int        items_sent = 0;
    int        computes_sent = 0;
    int        idle_mode = 0;

    always #5 aclk = ~aclk;

    blocked_matrix_multiply_accumulate i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_row          (s_row),
        .s_col          (s_col),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_compute_done (m_compute_done)
    );

    function automatic int eff_reg(input logic [CFG_W-1:0] r);
        if (r < 1) return 1;
        if (r > ORDER) return ORDER;
        return int'(r);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Whether a compute with the current sizes fits the cost budget and A and B are covered
    function automatic bit compute_allowed();
        int n, g, s, span;
        longint cost;
        n = eff_reg(size_reg);
        g = eff_reg(grid_reg);
        s = n / g;
        span = g * s;
        cost = longint'(g) * g * g * s * s * (s + 5);
        if (cost > COMPUTE_BUDGET) return 1'b0;
        for (int r = 0; r < span; r++)
            for (int c = 0; c < span; c++)
                if (!a_written[r*ORDER+c] || !b_written[r*ORDER+c]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic accumulate_product();
        int n, g, s, kb;
        longint dot, acc;
        n = eff_reg(size_reg);
        g = eff_reg(grid_reg);
        s = n / g;
        for (int bi = 0; bi < g; bi++)
            for (int bj = 0; bj < g; bj++) begin
                kb = (bi + bj) % g;
                for (int step = 0; step < g; step++) begin
                    for (int mi = bi*s; mi < (bi+1)*s; mi++)
                        for (int mj = bj*s; mj < (bj+1)*s; mj++) begin
                            dot = 0;
                            for (int mk = kb*s; mk < (kb+1)*s; mk++)
                                dot += longint'(a_mirror[mi*ORDER+mk]) *
                                       longint'(b_mirror[mk*ORDER+mj]);
                            acc = longint'(c_mirror[mi*ORDER+mj]) + dot;
                            c_mirror[mi*ORDER+mj] = VALUE_W'(clamp(acc, ACC_MIN, ACC_MAX));
                        end
                    kb = (kb + 1) % g;
                end
            end
    endtask

    // Advance the predictor by one request; returns 1 where a result is due
    task automatic predict_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] row,
                                   input logic [IDX_W-1:0] col,
                                   input logic signed [VALUE_W-1:0] value,
                                   output bit has_result, output c_result_t res);
        int idx;
        idx = int'(row) * ORDER + int'(col);
        has_result = 1'b0;
        res.value = '0;
        res.done = 1'b0;
        case (req)
            REQ_LOAD_A: begin
                a_mirror[idx] = AB_W'(clamp(longint'(value), -32768, 32767));
                a_written[idx] = 1'b1;
            end
            REQ_LOAD_B: begin
                b_mirror[idx] = AB_W'(clamp(longint'(value), -32768, 32767));
                b_written[idx] = 1'b1;
            end
            REQ_LOAD_C: c_mirror[idx] = value;
            REQ_COMPUTE: begin
                accumulate_product();
                has_result = 1'b1;
                res.done = 1'b1;
            end
            REQ_READ_C: begin
                has_result = 1'b1;
                res.value = c_mirror[idx];
            end
            default: ;
        endcase
    endtask

    function automatic bit sender_idles();
        case (idle_mode)
            0: return $urandom_range(99) < 6;
            1: return $urandom_range(99) < 81;
            default: return 1'b0;
        endcase
    endfunction

    task automatic issue_request(input stim_row_t item);
        bit        due;
        c_result_t res;
        while (sender_idles()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= item.req;
        s_row      <= item.row;
        s_col      <= item.col;
        s_value    <= item.value;
        do @(posedge aclk); while (!s_ready);
        predict_request(item.req, item.row, item.col, item.value, due, res);
        if (item.typed) begin
            res.value = item.exp_value;
            res.done = item.exp_done;
        end
        if (due) pending_results.push_back(res);
        items_sent++;
        if (item.req == REQ_COMPUTE) computes_sent++;
        idle_mode = items_sent < 300 ? 0 : (items_sent < 600 ? 1 : 2);
    endtask

    // Hold the sender until every result is back and the block has settled
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_sizes(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] g);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_MATRIX_SIZE;
        cfg_wr_data <= n;
        @(posedge aclk);
        cfg_index   <= CFG_GRID_COUNT;
        cfg_wr_data <= g;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        size_reg = n;
        grid_reg = g;
        @(posedge aclk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       return {1'b0, {(VALUE_W-1){1'b1}}};
            1:       return {1'b1, {(VALUE_W-1){1'b0}}};
            2, 3:    return raw[VALUE_W-1:0];
            default: return VALUE_W'($signed(raw[AB_W-1:0]));
        endcase
    endfunction

    function automatic stim_row_t plain(input logic [REQ_W-1:0] req, input int row,
                                       input int col, input logic signed [VALUE_W-1:0] v);
        stim_row_t t;
        t.req = req;
        t.row = IDX_W'(row);
        t.col = IDX_W'(col);
        t.value = v;
        t.typed = 1'b0;
        t.exp_value = '0;
        t.exp_done = 1'b0;
        return t;
    endfunction

    function automatic stim_row_t typed(input logic [REQ_W-1:0] req, input int row, input int col,
                                        input logic signed [VALUE_W-1:0] exp_v, input logic exp_d);
        stim_row_t t;
        t = plain(req, row, col, '0);
        t.typed = 1'b1;
        t.exp_value = exp_v;
        t.exp_done = exp_d;
        return t;
    endfunction

    // Load A and B over the span that compute touches, when that span holds at most 100 elements
    task automatic fill_operands();
        int span;
        span = (eff_reg(size_reg) / eff_reg(grid_reg)) * eff_reg(grid_reg);
        if (longint'(span) * span > 100) return;
        for (int r = 0; r < span; r++)
            for (int c = 0; c < span; c++) begin
                issue_request(plain(REQ_LOAD_A, r, c, pick_value()));
                issue_request(plain(REQ_LOAD_B, r, c, pick_value()));
            end
    endtask

    task automatic random_phase(input int count);
        stim_row_t t;
        int        lim, pick;
        lim = eff_reg(size_reg);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            t = plain(REQ_READ_C, 0, 0, pick_value());
            if ($urandom_range(3) == 0) begin
                t.row = IDX_W'($urandom_range(ORDER-1));
                t.col = IDX_W'($urandom_range(ORDER-1));
            end else begin
                t.row = IDX_W'($urandom_range(lim-1));
                t.col = IDX_W'($urandom_range(lim-1));
            end
            if (pick < 30)      t.req = REQ_LOAD_A;
            else if (pick < 50) t.req = REQ_LOAD_B;
            else if (pick < 60) t.req = REQ_LOAD_C;
            else if (pick < 70) t.req = compute_allowed() ? REQ_COMPUTE : REQ_READ_C;
            else if (pick < 95) t.req = REQ_READ_C;
            else                t.req = REQ_W'($urandom_range(REQ_NONE_LAST, REQ_NONE_FIRST));
            issue_request(t);
        end
    endtask

    // receiver side
    always @(posedge aclk) begin
        case (idle_mode)
            0: m_ready <= $urandom_range(99) >= 81;
            1: m_ready <= $urandom_range(99) >= 6;
            default: m_ready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        c_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d done %0b",
                             m_result_value, m_compute_done);
            end else begin
                want = pending_results.pop_front();
                if (m_result_value !== want.value || m_compute_done !== want.done) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected value %0d done %0b, got %0d done %0b",
                                 want.value, want.done, m_result_value, m_compute_done);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("blocked_matrix_multiply_accumulate regression: fail");
        $finish;
    end

    initial begin
        stim_row_t directed [$];
        for (int i = 0; i < ORDER*ORDER; i++) begin
            a_mirror[i] = '0;
            b_mirror[i] = '0;
            c_mirror[i] = '0;
            a_written[i] = 1'b0;
            b_written[i] = 1'b0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // C store is cleared by reset
        issue_request(typed(REQ_READ_C, 0, 0, '0, 1'b0));
        issue_request(typed(REQ_READ_C, 63, 63, '0, 1'b0));
        drain();
        write_sizes(7'd2, 7'd1);

        directed.push_back(plain(REQ_LOAD_A, 0, 0, 40'sd1000000));
        directed.push_back(plain(REQ_LOAD_A, 0, 1, -40'sd1000000));
        directed.push_back(plain(REQ_LOAD_A, 1, 0, 40'sd32767));
        directed.push_back(plain(REQ_LOAD_A, 1, 1, -40'sd32768));
        directed.push_back(plain(REQ_LOAD_B, 0, 0, 40'sd256));
        directed.push_back(plain(REQ_LOAD_B, 0, 1, {1'b1, {(VALUE_W-1){1'b0}}}));
        directed.push_back(plain(REQ_LOAD_B, 1, 0, {1'b0, {(VALUE_W-1){1'b1}}}));
        directed.push_back(plain(REQ_LOAD_B, 1, 1, -40'sd1));
        directed.push_back(plain(REQ_LOAD_C, 0, 0, {1'b0, {(VALUE_W-1){1'b1}}}));
        directed.push_back(typed(REQ_READ_C, 0, 0, {1'b0, {(VALUE_W-1){1'b1}}}, 1'b0));
        directed.push_back(plain(REQ_LOAD_C, 1, 1, {1'b1, {(VALUE_W-1){1'b0}}}));
        directed.push_back(typed(REQ_COMPUTE, 0, 0, '0, 1'b1));
        directed.push_back(plain(REQ_READ_C, 0, 0, '0));
        directed.push_back(plain(REQ_READ_C, 0, 1, '0));
        directed.push_back(plain(REQ_READ_C, 1, 0, '0));
        directed.push_back(plain(REQ_READ_C, 1, 1, '0));
        directed.push_back(plain(REQ_LOAD_C, 63, 63, {1'b1, {(VALUE_W-1){1'b0}}}));
        directed.push_back(typed(REQ_READ_C, 63, 63, {1'b1, {(VALUE_W-1){1'b0}}}, 1'b0));
        directed.push_back(plain(REQ_NONE_FIRST, 5, 5, '1));
        directed.push_back(plain(REQ_NONE_LAST, 63, 0, '1));
        directed.push_back(plain(REQ_LOAD_A, 40, 50, '1));
        directed.push_back(typed(REQ_READ_C, 10, 10, '0, 1'b0));
        foreach (directed[i]) issue_request(directed[i]);
        drain();

        // grid wider than the order: compute leaves C alone
        write_sizes(7'd5, 7'd127);
        issue_request(typed(REQ_COMPUTE, 0, 0, '0, 1'b1));
        random_phase(60);
        drain();
        write_sizes(7'd0, 7'd0);
        fill_operands();
        random_phase(120);
        drain();
        write_sizes(7'd8, 7'd2);
        fill_operands();
        random_phase(90);
        drain();
        write_sizes(7'd6, 7'd3);
        fill_operands();
        random_phase(60);
        drain();
        write_sizes(7'd127, 7'd64);
        random_phase(100);
        drain();
        write_sizes(7'd7, 7'd3);
        fill_operands();
        random_phase(110);
        drain();
        write_sizes(7'd64, 7'd8);
        random_phase(60);
        drain();
        repeat (20) @(posedge aclk);

        $display("covered %0d requests, %0d computes, %0d results over eight size settings",
                 items_sent, computes_sent, results_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("blocked_matrix_multiply_accumulate regression: pass");
        else
            $display("blocked_matrix_multiply_accumulate regression: fail");
        $finish;
    end

endmodule
